[sv/ubrfd_pkg.sv]
// ============================================================================
// ubrfd_pkg: shared types and constants of the bulk receive deframer
// Word layouts of both channels, configuration codes, event codes and the
// control bundles that travel between the front, the queue and the back.
// ============================================================================
package ubrfd_pkg;

  // Width of the frame length field in the status word (allowed 11 to 16).
  localparam int LEN_FIELD_BITS_DEF = 14;
  // Number of entries in the result queue between front and back.
  localparam int QUEUE_DEPTH_DEF    = 4;

  localparam int MAX_LEN_W  = 14;
  localparam int CFG_DATA_W = 14;
  localparam int OFFSET_W   = 2;

  localparam int HDR_BYTES  = 4;
  localparam int CRC_BYTES  = 4;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 14'd1526;
  localparam logic [OFFSET_W-1:0]  OFFSET_RESET  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_IDX_MAX_LEN = 1'b0;
  localparam logic CFG_IDX_OFFSET  = 1'b1;

  // Event codes reported with a result word.
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_ERROR    = 2'd1;
  localparam logic [1:0] EV_OVERSIZE = 2'd2;
  localparam logic [1:0] EV_TRUNC    = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_last;
  } in_word_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       frame_last;
    logic [1:0] event_res;
  } out_word_t;

  localparam int OUT_W = $bits(out_word_t);

  typedef struct packed {
    logic                  we;
    logic                  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[sv/ubrfd_parser.sv]
// ============================================================================
// ubrfd_parser: front end of the deframer
// Accepts one buffer byte per cycle while the queue has room, walks the
// header, offset, frame and padding phases, and pushes a result word into
// the queue per delivered byte or event. Holds the configuration registers.
// ============================================================================
module ubrfd_parser #(
  parameter int LEN_BITS = ubrfd_pkg::LEN_FIELD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  ubrfd_pkg::in_word_t    in_data_i,
  output logic                   in_stall_o,
  input  ubrfd_pkg::cfg_write_t  cfg_i,
  input  ubrfd_pkg::q_status_t   q_stat_i,
  output ubrfd_pkg::push_t       push_o
);
  import ubrfd_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_OFFSET = 3'd1;
  localparam logic [2:0] PH_FRAME  = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_ABORT  = 3'd4;

  localparam int CMP_W = (LEN_BITS > MAX_LEN_W) ? LEN_BITS : MAX_LEN_W;

  logic [MAX_LEN_W-1:0] max_len_q;
  logic [OFFSET_W-1:0]  offset_q;

  logic [2:0]          phase_q, phase_d;
  logic [LEN_BITS-1:0] cnt_q, cnt_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic                err_q, err_d;
  logic [7:0]          b2_q, b2_d;
  logic                skip_q, skip_d;
  logic [1:0]          pad_q, pad_d;

  logic                accept;
  logic [LEN_BITS-1:0] cnt_inc;
  logic [LEN_BITS-1:0] len_new;
  logic [1:0]          pad_new;
  logic                done;
  out_word_t           res;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_inc    = cnt_q + LEN_BITS'(1);
  assign len_new    = LEN_BITS'({in_data_i.in_byte, b2_q});
  assign pad_new    = 2'(2'd0 - (len_new[1:0] + offset_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      offset_q  <= OFFSET_RESET;
    end else if (cfg_i.we) begin
      if (cfg_i.idx == CFG_IDX_MAX_LEN) begin
        max_len_q <= cfg_i.data[MAX_LEN_W-1:0];
      end else begin
        offset_q <= cfg_i.data[OFFSET_W-1:0];
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    err_d   = err_q;
    b2_d    = b2_q;
    skip_d  = skip_q;
    pad_d   = pad_q;
    res     = '0;
    done    = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (cnt_q[1:0] == 2'd1) begin
            err_d = in_data_i.in_byte[7];
          end
          if (cnt_q[1:0] == 2'd2) begin
            b2_d = in_data_i.in_byte;
          end
          cnt_d = cnt_inc;
          if (cnt_q == LEN_BITS'(HDR_BYTES - 1)) begin
            len_d  = len_new;
            pad_d  = pad_new;
            skip_d = 1'b0;
            if (!err_q && (CMP_W'(len_new) > CMP_W'(max_len_q))) begin
              res.event_res = EV_OVERSIZE;
              phase_d       = PH_ABORT;
            end else begin
              if (err_q) begin
                skip_d        = 1'b1;
                res.event_res = EV_ERROR;
              end
              cnt_d = '0;
              if (offset_q != '0) begin
                phase_d = PH_OFFSET;
              end else if (len_new != '0) begin
                phase_d = PH_FRAME;
              end else if (pad_new != 2'd0) begin
                phase_d = PH_PAD;
              end else begin
                phase_d = PH_HEADER;
                skip_d  = 1'b0;
              end
            end
          end
        end
        PH_OFFSET: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= LEN_BITS'(offset_q)) begin
            cnt_d = '0;
            if (len_q != '0) begin
              phase_d = PH_FRAME;
            end else if (pad_q != 2'd0) begin
              phase_d = PH_PAD;
            end else begin
              phase_d = PH_HEADER;
              skip_d  = 1'b0;
            end
          end
        end
        PH_FRAME: begin
          if (!skip_q && (len_q > LEN_BITS'(CRC_BYTES)) &&
              (cnt_q < len_q - LEN_BITS'(CRC_BYTES))) begin
            res.byte_valid = 1'b1;
            res.out_byte   = in_data_i.in_byte;
            res.frame_last = (cnt_q == len_q - LEN_BITS'(CRC_BYTES + 1));
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) begin
            if (pad_q != 2'd0) begin
              phase_d = PH_PAD;
            end else begin
              phase_d = PH_HEADER;
              cnt_d   = '0;
              skip_d  = 1'b0;
            end
          end
        end
        PH_PAD: begin
          pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0) begin
            phase_d = PH_HEADER;
            cnt_d   = '0;
            skip_d  = 1'b0;
          end
        end
        PH_ABORT: begin
          phase_d = PH_ABORT;
        end
        default: begin
          phase_d = PH_HEADER;
          cnt_d   = '0;
          skip_d  = 1'b0;
        end
      endcase

      if (in_data_i.buffer_last) begin
        done = ((phase_d == PH_HEADER) && (cnt_d == '0)) ||
               (phase_d == PH_PAD) || (phase_d == PH_ABORT);
        if (!done && (res.event_res != EV_OVERSIZE)) begin
          res.event_res = EV_TRUNC;
        end
        phase_d = PH_HEADER;
        cnt_d   = '0;
        skip_d  = 1'b0;
        pad_d   = 2'd0;
      end
    end
  end

  assign push_o.valid = accept && (res.byte_valid || (res.event_res != EV_NONE));
  assign push_o.word  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      len_q   <= '0;
      skip_q  <= 1'b0;
      pad_q   <= 2'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      pad_q   <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    b2_q  <= b2_d;
  end

  // Nothing leaves the parser while the rest of a buffer is being dropped.
  a_abort_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (phase_q == PH_ABORT)) |-> !push_o.valid)
    else $error("result pushed while aborting a buffer");

  // The end of a buffer always brings the parser back to a fresh header.
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.buffer_last) |=> ((phase_q == PH_HEADER) && (cnt_q == '0)))
    else $error("parser not at header start after buffer end");

  // A frame end marker only comes with a delivered byte.
  a_last_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.valid && push_o.word.frame_last) |-> push_o.word.byte_valid)
    else $error("frame_last without a delivered byte");

endmodule

[sv/ubrfd_queue.sv]
// ============================================================================
// ubrfd_queue: short result queue between front and back
// A small register queue with write and read pointers and an entry count.
// ============================================================================
module ubrfd_queue #(
  parameter int WIDTH = ubrfd_pkg::OUT_W,
  parameter int DEPTH = ubrfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     push_data_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     pop_data_o,
  output ubrfd_pkg::q_status_t status_o
);
  import ubrfd_pkg::*;

  // The user keeps DEPTH a power of two so pointers wrap; this is not enforced.
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[sv/ubrfd_out_stage.sv]
// ============================================================================
// ubrfd_out_stage: back end of the deframer
// Moves result words from the queue into the output register and holds each
// one until the receiver takes it.
// ============================================================================
module ubrfd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ubrfd_pkg::q_status_t q_stat_i,
  input  ubrfd_pkg::out_word_t q_data_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  output ubrfd_pkg::out_word_t out_data_o,
  input  logic                 out_stall_i
);
  import ubrfd_pkg::*;

  logic      valid_q, valid_d;
  out_word_t data_q;

  assign pop_o   = !q_stat_i.empty && (!valid_q || !out_stall_i);
  assign valid_d = pop_o || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= q_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[sv/usb_bulk_rx_frame_deframer.sv]
// ============================================================================
// usb_bulk_rx_frame_deframer: bulk receive buffer deframer
// Splits a received bulk buffer into frames, strips status words, offsets,
// CRC bytes and padding, and reports error, oversize and truncation events.
// ============================================================================
//
//   Port group    Direction  Handshake               Word
//   in_*          in         in_valid_i/in_stall_o   in_word_t (byte, buffer end)
//   out_*         out        out_valid_o/out_stall_i out_word_t (byte, marks, event)
//   cfg_*         in         cfg_we_i                register index and data
//
// One buffer byte is accepted every cycle while the result queue has room;
// the parser's per-byte phase update sets this rate. A result word passes
// through the queue and then the output register on its way to the output.
// Reset clears the phase machine, the queue pointers and the output valid;
// no clearing pass is needed, the block takes bytes right after reset.
// in_stall_o rises only when the queue is full, so a stalled output is
// absorbed by the queue and the output register before input stalls.
//
// Only bytes that deliver frame data or report an event produce a word;
// status words, offsets, CRC bytes and padding are consumed silently.
// Configuration is expected to change only while the block is idle.
module usb_bulk_rx_frame_deframer #(
  parameter int LENGTH_FIELD_BITS = ubrfd_pkg::LEN_FIELD_BITS_DEF,
  parameter int QUEUE_DEPTH       = ubrfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  ubrfd_pkg::in_word_t               in_data_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  output ubrfd_pkg::out_word_t              out_data_o,
  input  logic                              out_stall_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [ubrfd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ubrfd_pkg::*;

  cfg_write_t cfg;
  push_t      push;
  q_status_t  q_stat;
  logic       pop;
  logic [OUT_W-1:0] q_data;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  // Front: parses the byte stream and classifies every byte.
  ubrfd_parser #(
    .LEN_BITS (LENGTH_FIELD_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .cfg_i      (cfg),
    .q_stat_i   (q_stat),
    .push_o     (push)
  );

  // Queue: lets the parser keep going while the receiver stalls.
  ubrfd_queue #(
    .WIDTH (OUT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push.valid),
    .push_data_i (push.word),
    .pop_i       (pop),
    .pop_data_o  (q_data),
    .status_o    (q_stat)
  );

  // Back: registered output that holds a word until it is taken.
  ubrfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_data_i    (out_word_t'(q_data)),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

[test/usb_bulk_rx_frame_deframer_tb.sv]
// ============================================================================
// usb_bulk_rx_frame_deframer_tb: self-checking bench for the bulk rx deframer
// Feeds whole bulk buffers built from status words, offsets, frame bodies and
// padding, mirrors the parser byte by byte and compares every result word.
// ============================================================================
`timescale 1ns / 1ps

// Mirrors the deframer state, turns each accepted buffer byte into the result
// word it should cause, and matches result words in order.
class rx_deframe_tracker;
  typedef enum int {PH_HDR, PH_OFS, PH_BODY, PH_PAD, PH_ABORT} parse_phase_e;

  parse_phase_e phase;
  bit [31:0]    status;
  int           count;
  int           flen;
  int           pad;
  bit           skip;
  int           max_len;
  int           offset;
  int           failures;
  ubrfd_pkg::out_word_t due_words[$];

  function new();
    max_len  = ubrfd_pkg::MAX_LEN_RESET;
    offset   = ubrfd_pkg::OFFSET_RESET;
    failures = 0;
    flen     = 0;
    pad      = 0;
    to_header();
  endfunction

  function void to_header();
    phase  = PH_HDR;
    count  = 0;
    status = '0;
    skip   = 1'b0;
  endfunction

  function void finish_body();
    if (pad == 0) to_header();
    else phase = PH_PAD;
  endfunction

  function void enter_body();
    count = 0;
    if (flen == 0) finish_body();
    else phase = PH_BODY;
  endfunction

  function void set_reg(logic idx, logic [ubrfd_pkg::CFG_DATA_W-1:0] value);
    if (idx == ubrfd_pkg::CFG_IDX_MAX_LEN) max_len = value;
    else offset = value[1:0];
  endfunction

  // One accepted buffer byte: advance the parse and queue the word it causes.
  function void take_buffer_byte(ubrfd_pkg::in_word_t w);
    bit                   hit;
    bit [7:0]             ob;
    bit                   fl;
    logic [1:0]           ev;
    bit                   done;
    int                   len_mask;
    ubrfd_pkg::out_word_t r;
    hit      = 1'b0;
    ob       = '0;
    fl       = 1'b0;
    ev       = ubrfd_pkg::EV_NONE;
    len_mask = (1 << ubrfd_pkg::LEN_FIELD_BITS_DEF) - 1;
    case (phase)
      PH_HDR: begin
        status = status | (32'(w.in_byte) << (8 * (count % 4)));
        count++;
        if (count >= 4) begin
          flen = int'(status >> 16) & len_mask;
          pad  = (4 - ((flen + offset) % 4)) % 4;
          skip = 1'b0;
          if (status[15]) begin
            skip = 1'b1;
            ev   = ubrfd_pkg::EV_ERROR;
          end else if (flen > max_len) begin
            ev    = ubrfd_pkg::EV_OVERSIZE;
            phase = PH_ABORT;
          end
          if (phase != PH_ABORT) begin
            count = 0;
            if (offset == 0) enter_body();
            else phase = PH_OFS;
          end
        end
      end
      PH_OFS: begin
        count++;
        if (count >= offset) enter_body();
      end
      PH_BODY: begin
        if (!skip && flen > 4 && count < flen - 4) begin
          hit = 1'b1;
          ob  = w.in_byte;
          fl  = (count == flen - 5);
        end
        count++;
        if (count >= flen) finish_body();
      end
      PH_PAD: begin
        pad = (pad - 1) & 3;
        if (pad == 0) to_header();
      end
      default: ;
    endcase
    if (w.buffer_last) begin
      done = (phase == PH_HDR && count == 0) || phase == PH_PAD || phase == PH_ABORT;
      if (!done && ev != ubrfd_pkg::EV_OVERSIZE) ev = ubrfd_pkg::EV_TRUNC;
      to_header();
      pad = 0;
    end
    if (hit || ev != ubrfd_pkg::EV_NONE) begin
      r.byte_valid = hit;
      r.out_byte   = ob;
      r.frame_last = fl;
      r.event_res  = ev;
      due_words.push_back(r);
    end
  endfunction

  function void flag(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  function void match_result(ubrfd_pkg::out_word_t got);
    ubrfd_pkg::out_word_t want;
    if (due_words.size() == 0) begin
      flag($sformatf("unexpected word at %0t: v=%0b byte=%02h last=%0b ev=%0d",
                     $time, got.byte_valid, got.out_byte, got.frame_last, got.event_res));
      return;
    end
    want = due_words.pop_front();
    if (got.byte_valid !== want.byte_valid || got.out_byte !== want.out_byte ||
        got.frame_last !== want.frame_last || got.event_res !== want.event_res)
      flag($sformatf({"mismatch at %0t: expected v=%0b byte=%02h last=%0b ev=%0d,",
                      " got v=%0b byte=%02h last=%0b ev=%0d"}, $time,
                     want.byte_valid, want.out_byte, want.frame_last, want.event_res,
                     got.byte_valid, got.out_byte, got.frame_last, got.event_res));
  endfunction

  function int pending();
    return due_words.size();
  endfunction

  function bit failed();
    if (due_words.size() != 0)
      flag($sformatf("%0d expected words never arrived", due_words.size()));
    return failures != 0;
  endfunction
endclass

module usb_bulk_rx_frame_deframer_tb;
  import ubrfd_pkg::*;

  // All block inputs start from known values; the bench drives them with
  // nonblocking assignments right at the rising clock edge.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  in_word_t              in_data_i   = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  out_word_t             out_data_o;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic                  cfg_idx_i   = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  rx_deframe_tracker tracker = new();

  // Bytes of the bulk buffer being assembled, and the bench's own copy of
  // the register settings, used to shape frames that the block will accept.
  in_word_t rx_buffer[$];
  int       cur_max_len = MAX_LEN_RESET;
  int       cur_offset  = OFFSET_RESET;
  int       bytes_sent  = 0;

  // Idle percentages of both sides, and a request for one long output hold.
  int       tx_pct   = 0;
  int       rx_pct   = 0;
  int       hold_req = 0;

  usb_bulk_rx_frame_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Both channels are sampled at the edge itself, before any of the block's
  // registers or the bench's drivers change, so a word counts as moved exactly
  // when valid was high and stall low going into that edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) tracker.take_buffer_byte(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) tracker.match_result(out_data_o);
  end

  // Output side. A long hold is counted down here on its own, so the sender
  // keeps offering bytes until the internal queue fills and the input stalls.
  initial begin : receiver
    int held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        held     = hold_req;
        hold_req = 0;
      end
      if (held > 0) begin
        out_stall_i <= 1'b1;
        held--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  // Offers one word and holds it, unchanged, until the block takes it.
  // Random gaps before the word are what makes the sender idle.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // Drops valid and waits until every predicted word has come out. It always
  // advances at least one edge, so valid is never lowered and raised in the
  // same step.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // Drains the block and then lets it idle on before a register changes.
  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    tracker.set_reg(idx, value);
    cfg_we_i   <= 1'b0;
  endtask

  // The offset register only uses its two low bits; the upper data bits are
  // random so every bit of the write data toggles.
  task automatic configure(input int max_len, input int offset);
    write_reg(CFG_IDX_MAX_LEN, CFG_DATA_W'(max_len));
    write_reg(CFG_IDX_OFFSET, {12'($urandom), 2'(offset)});
    cur_max_len = max_len;
    cur_offset  = offset;
  endtask

  function automatic void push_byte(input logic [7:0] b);
    rx_buffer.push_back('{in_byte: b, buffer_last: 1'b0});
  endfunction

  // Status word, little endian: length in bits 16 to 29, error flag in bit
  // 15. The bits outside those fields are random since the parser ignores them.
  function automatic void add_status(input int len, input bit err);
    logic [31:0] sw;
    sw        = $urandom;
    sw[29:16] = 14'(len);
    sw[15]    = err;
    for (int k = 0; k < 4; k++) push_byte(sw[8*k +: 8]);
  endfunction

  function automatic void add_frame(input int len, input bit err);
    add_status(len, err);
    repeat (cur_offset) push_byte(8'($urandom));
    repeat (len) push_byte(8'($urandom));
    repeat ((4 - ((len + cur_offset) % 4)) % 4) push_byte(8'($urandom));
  endfunction

  // Mostly well-formed frames within the current limit; some error frames
  // and some oversize headers. An oversize header throws away the rest of the
  // buffer, so it closes the buffer after a few junk bytes.
  function automatic bit add_random_frame();
    int roll;
    int cap;
    roll = $urandom_range(99);
    if (roll < 10) begin
      add_frame($urandom_range(60), 1'b1);
      return 1'b0;
    end
    if (roll < 18 && cur_max_len < 16383) begin
      add_status($urandom_range(cur_max_len + 1, 16383), 1'b0);
      repeat ($urandom_range(6)) push_byte(8'($urandom));
      return 1'b1;
    end
    cap = (cur_max_len < 40) ? cur_max_len : 40;
    if ($urandom_range(9) == 0) cap = (cur_max_len < 200) ? cur_max_len : 200;
    add_frame($urandom_range(cap), 1'b0);
    return 1'b0;
  endfunction

  // Sends the assembled buffer with the end mark on its final byte.
  task automatic send_buffer();
    in_word_t w;
    for (int i = 0; i < rx_buffer.size(); i++) begin
      w             = rx_buffer[i];
      w.buffer_last = (i == rx_buffer.size() - 1);
      send_word(w);
    end
    rx_buffer.delete();
  endtask

  // One random buffer: usually one to four frames, sometimes cut short so
  // that it ends inside a header, an offset, a body or padding, and sometimes
  // pure noise, whose random status bytes land in any of the parser's branches.
  task automatic run_random_buffer();
    int frames;
    int keep;
    bit closed;
    closed = 1'b0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
    end else begin
      frames = $urandom_range(1, 4);
      for (int i = 0; i < frames && !closed; i++) closed = add_random_frame();
      if (!closed && $urandom_range(99) < 15) begin
        keep = $urandom_range(1, rx_buffer.size());
        while (rx_buffer.size() > keep) void'(rx_buffer.pop_back());
      end
    end
    send_buffer();
  endtask

  initial begin : stimulus
    int target;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed buffers, run with the register values left by reset.
    // A five byte frame delivers its single byte marked last; the buffer
    // then ends in the padding, which is not flagged.
    add_frame(5, 1'b0);
    send_buffer();
    // An empty frame with the error flag: reported and skipped, ends in pad.
    add_frame(0, 1'b1);
    send_buffer();
    // Largest length field, far above the limit: the buffer is aborted and
    // the byte after it, carrying the end mark, is silently dropped.
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h00);
    send_buffer();
    // A buffer that ends after two status bytes is truncated.
    push_byte(8'hAB);
    push_byte(8'hCD);
    send_buffer();

    // Random phases: each one writes both registers while the block is idle,
    // then runs a share of the random buffers under one idling pattern.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(1526, 2);
        1: configure(0, 0);
        2: configure(16383, 3);
        3: configure(20, 1);
        4: configure($urandom_range(64), $urandom_range(3));
        5: configure(1514, 0);
        6: configure($urandom_range(100), 2);
        default: configure(16383, 1);
      endcase
      case (p % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 81; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 81; end
        default: begin tx_pct = 11; rx_pct = 11; end
      endcase
      if (p == 0) begin
        // The receiver holds off for a long stretch while three full frames
        // stream in, so the queue fills and the block stalls its input.
        hold_req = 300;
        repeat (3) add_frame(40, 1'b0);
        send_buffer();
        // The sender then rests until every predicted word has arrived.
        wait_drained();
      end
      target = bytes_sent + 110;
      while (bytes_sent < target) run_random_buffer();
    end

    tx_pct = 0;
    rx_pct = 0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (tracker.failed()) begin
      $display("simulation failed");
    end else begin
      $display("simulation ok");
    end
    $finish;
  end

  // Far beyond the slowest correct run of this stimulus.
  initial begin : watchdog
    #20_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule
